### rtl/ggiv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggiv_pkg
// Types, constants and constant tables of the Gaussian gust inlet block.
// ----------------------------------------------------------------------------
package ggiv_pkg;

  localparam int COORD_W  = 20;               // one Q.10 vector component
  localparam int FRAC     = 10;
  localparam int VEC_W    = 3 * COORD_W;      // packed vector register
  localparam int TAB_AW   = 8;
  localparam int TAB_DEPTH = 1 << TAB_AW;
  localparam int SIN_W    = 18;               // signed Q.16
  localparam int EXP_W    = 17;               // unsigned Q.16
  localparam int PROD_W   = 2 * COORD_W;
  localparam int WIDE_W   = 48;               // headroom for sums before saturation
  localparam int K_W      = 52;               // 1/(2R^2) as unsigned Q.32
  localparam int K_HALF   = K_W / 2;
  localparam int RSQ_W    = 40;
  localparam int PHASE_W  = 26;               // Q.26 turns
  localparam int Q_W      = 32;
  localparam int QK_W     = Q_W + K_W;
  localparam int EXP_LIM  = 46;               // x >= 16.0 when q*k reaches 2^46

  localparam logic [K_W-1:0] K_RESET = K_W'(1) << 31;   // radius 1.0

  localparam logic signed [WIDE_W-1:0] SAT_HI = (WIDE_W'(1) <<< (COORD_W - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = PI_Q30 / 2;
  localparam longint ONE_Q30     = 64'sd1073741824;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_SQUARE,
    DIV_RUN
  } div_state_e;

  typedef enum logic [2:0] {
    REG_REF_VEL,
    REG_GUST_DIR,
    REG_SRC_POINT,
    REG_SRC_AXIS,
    REG_AMPLITUDE,
    REG_FREQUENCY,
    REG_WIDTH,
    REG_ENABLE
  } reg_idx_e;

  typedef logic signed [SIN_W-1:0] sin_tab_t [TAB_DEPTH];
  typedef logic        [EXP_W-1:0] exp_tab_t [TAB_DEPTH];

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[COORD_W-1:0];
  endfunction

  function automatic longint q30_to_q16(input longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  // Shift-and-subtract division that truncates toward zero; the divisor is positive.
  function automatic longint div_trunc(input longint num, input longint den);
    longint mag, quo, rem;
    mag = (num < 0) ? -num : num;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((mag >>> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (64'sd1 <<< b);
      end
    end
    return (num < 0) ? -quo : quo;
  endfunction

  function automatic logic signed [SIN_W-1:0] sin_entry(input int i);
    longint th, t2, term, s, r;
    bit     neg;
    neg = 1'b0;
    th  = (64'sd2 * PI_Q30 * longint'(i)) >>> TAB_AW;
    if (th > PI_Q30) begin
      th  = th - PI_Q30;
      neg = 1'b1;
    end
    if (th > HALF_PI_Q30) th = PI_Q30 - th;
    t2   = (th * th) >>> 30;
    term = th;
    s    = th;
    for (int n = 1; n <= 6; n++) begin
      term = -div_trunc((term * t2) >>> 30, longint'((2 * n) * (2 * n + 1)));
      s    = s + term;
    end
    r = q30_to_q16(neg ? -s : s);
    return r[SIN_W-1:0];
  endfunction

  function automatic logic [EXP_W-1:0] exp_entry(input int i);
    longint y, term, e, r;
    y    = (((longint'(16) <<< 30) * longint'(i)) >>> TAB_AW) >>> 4;
    term = ONE_Q30;
    e    = ONE_Q30;
    for (int n = 1; n <= 12; n++) begin
      term = -div_trunc((term * y) >>> 30, longint'(n));
      e    = e + term;
    end
    if (e < 0) e = 0;
    for (int n = 0; n < 4; n++) e = (e * e) >>> 30;
    r = q30_to_q16(e);
    return r[EXP_W-1:0];
  endfunction

  function automatic sin_tab_t build_sin();
    sin_tab_t t;
    for (int i = 0; i < TAB_DEPTH; i++) t[i] = sin_entry(i);
    return t;
  endfunction

  function automatic exp_tab_t build_exp();
    exp_tab_t t;
    for (int i = 0; i < TAB_DEPTH; i++) t[i] = exp_entry(i);
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin();
  localparam exp_tab_t EXP_TAB = build_exp();

endpackage
`default_nettype wire

### rtl/gaussian_gust_inlet_velocity.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_gust_inlet_velocity
// Inlet velocity of one face: reference velocity plus a sinusoidal gust
// weighted by a Gaussian of the distance from the source axis.
//
//   channel   direction  handshake            payload
//   face in   input      start / busy         face_x_i, face_y_i, face_z_i, sim_time_i
//   velocity  output     valid_o (one cycle)  vel_x_o, vel_y_o, vel_z_o
//   config    input      APB psel / penable   paddr, pwdata, prdata
//
// A face word enters in any cycle in which busy is low and its velocity leaves
// at the end of the 12-stage pipe; one word per cycle is sustained while busy is low.
// busy is high only after a source_width write, while the
// serial divider derives 1/(2R^2) one quotient bit per cycle.
// The result strobe lasts one cycle and cannot be held off; the pipe never stalls.
// Reset clears the valid bits, the divider and the registers to their defaults.
// ----------------------------------------------------------------------------
module gaussian_gust_inlet_velocity (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire  signed [ggiv_pkg::COORD_W-1:0] face_x_i,
  input  wire  signed [ggiv_pkg::COORD_W-1:0] face_y_i,
  input  wire  signed [ggiv_pkg::COORD_W-1:0] face_z_i,
  input  wire         [31:0]                sim_time_i,
  output logic                              valid_o,
  output logic signed [ggiv_pkg::COORD_W-1:0] vel_x_o,
  output logic signed [ggiv_pkg::COORD_W-1:0] vel_y_o,
  output logic signed [ggiv_pkg::COORD_W-1:0] vel_z_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire         [5:0]                 paddr,
  input  wire         [63:0]                pwdata,
  output logic        [63:0]                prdata,
  output logic                              pready
);
  import ggiv_pkg::*;

  localparam int NSTAGE = 12;
  localparam int S1_DLY = 6;   // s1 travels from stage 4 to stage 9

  // ---------------- configuration registers ----------------
  logic [VEC_W-1:0]   ref_vel_q, gust_dir_q, src_point_q, src_axis_q;
  logic [COORD_W-1:0] amp_q, freq_q, width_q;
  logic               enable_q;
  logic [K_W-1:0]     k_q;
  logic               wr_en;
  reg_idx_e           wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_vel_q   <= VEC_W'(1024);
      gust_dir_q  <= VEC_W'(1024) << (2 * COORD_W);
      src_point_q <= '0;
      src_axis_q  <= VEC_W'(1024) << COORD_W;
      amp_q       <= '0;
      freq_q      <= '0;
      width_q     <= COORD_W'(1024);
      enable_q    <= 1'b1;
    end else if (wr_en) begin
      case (wr_idx)
        REG_REF_VEL:   ref_vel_q   <= pwdata[VEC_W-1:0];
        REG_GUST_DIR:  gust_dir_q  <= pwdata[VEC_W-1:0];
        REG_SRC_POINT: src_point_q <= pwdata[VEC_W-1:0];
        REG_SRC_AXIS:  src_axis_q  <= pwdata[VEC_W-1:0];
        REG_AMPLITUDE: amp_q       <= pwdata[COORD_W-1:0];
        REG_FREQUENCY: freq_q      <= pwdata[COORD_W-1:0];
        REG_WIDTH:     width_q     <= pwdata[COORD_W-1:0];
        REG_ENABLE:    enable_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[5:3]))
      REG_REF_VEL:   prdata = 64'(ref_vel_q);
      REG_GUST_DIR:  prdata = 64'(gust_dir_q);
      REG_SRC_POINT: prdata = 64'(src_point_q);
      REG_SRC_AXIS:  prdata = 64'(src_axis_q);
      REG_AMPLITUDE: prdata = 64'(amp_q);
      REG_FREQUENCY: prdata = 64'(freq_q);
      REG_WIDTH:     prdata = 64'(width_q);
      REG_ENABLE:    prdata = 64'(enable_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------- serial divider for k = 2^51 / R^2 ----------------
  div_state_e       div_state_q, div_state_d;
  logic [RSQ_W-1:0] rsq_q, rsq_d;
  logic [RSQ_W-1:0] rem_q, rem_d;
  logic [RSQ_W:0]   rem_sh;
  logic [K_W-1:0]   quo_q, quo_d, k_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [COORD_W-1:0] rad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= DIV_IDLE;
      k_q         <= K_RESET;
      cnt_q       <= '0;
    end else begin
      div_state_q <= div_state_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsq_q <= rsq_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  always_comb begin
    div_state_d = div_state_q;
    rsq_d       = rsq_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    rad         = (width_q == '0) ? COORD_W'(1) : width_q;
    // The dividend is a single one bit followed by zeros.
    rem_sh      = {rem_q, (cnt_q == 6'(K_W - 1))};
    case (div_state_q)
      DIV_IDLE: begin
        if (wr_en && wr_idx == REG_WIDTH) div_state_d = DIV_SQUARE;
      end
      DIV_SQUARE: begin
        rsq_d       = RSQ_W'(rad) * RSQ_W'(rad);
        rem_d       = '0;
        quo_d       = '0;
        cnt_d       = 6'(K_W - 1);
        div_state_d = DIV_RUN;
      end
      DIV_RUN: begin
        if (rem_sh >= {1'b0, rsq_q}) begin
          rem_d = RSQ_W'(rem_sh - {1'b0, rsq_q});
          quo_d = {quo_q[K_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[RSQ_W-1:0];
          quo_d = {quo_q[K_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          k_d         = quo_d;
          div_state_d = DIV_IDLE;
        end
      end
      default: div_state_d = DIV_IDLE;
    endcase
  end

  assign busy = (div_state_q != DIV_IDLE);

  // ---------------- vector components ----------------
  logic signed [COORD_W-1:0] face_c [3];
  logic signed [COORD_W-1:0] sp_c [3], ax_c [3], dir_c [3], ref_c [3];

  assign face_c[0] = face_x_i;
  assign face_c[1] = face_y_i;
  assign face_c[2] = face_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sp_c[i]  = src_point_q[i*COORD_W +: COORD_W];
      ax_c[i]  = src_axis_q[i*COORD_W +: COORD_W];
      dir_c[i] = gust_dir_q[i*COORD_W +: COORD_W];
      ref_c[i] = ref_vel_q[i*COORD_W +: COORD_W];
    end
  end

  // ---------------- valid line ----------------
  logic [NSTAGE-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[NSTAGE-2:0], start & ~busy};
  end

  assign valid_o = vld_q[NSTAGE-1];

  // ---------------- datapath ----------------
  logic signed [COORD_W-1:0] r1_q [3], r2_q [3], r3_q [3], r4_q [3];
  logic        [PHASE_W-1:0] ph_q;
  logic        [45:0]        ft;
  logic signed [PROD_W-1:0]  ra_q [3], da_q [3], bb_q [3];
  logic signed [SIN_W-1:0]   sin_q;
  logic signed [COORD_W-1:0] d_q, b_q [3];
  logic signed [WIDE_W-1:0]  dsum;
  logic signed [37:0]        as_q;
  logic signed [21:0]        s1_q [S1_DLY];
  logic        [Q_W-1:0]     q_q;
  logic        [57:0]        plo_q, phi_q;
  logic        [QK_W-1:0]    qk;
  logic        [EXP_W-1:0]   e_q;
  logic signed [39:0]        se_q;
  logic signed [43:0]        g_q [3];
  logic signed [COORD_W-1:0] vel_q [3];

  assign ft   = 46'(freq_q) * 46'(sim_time_i[PHASE_W-1:0]);
  assign dsum = WIDE_W'(ra_q[0] >>> FRAC) + WIDE_W'(ra_q[1] >>> FRAC)
              + WIDE_W'(ra_q[2] >>> FRAC);
  assign qk   = (QK_W'(phi_q) << K_HALF) + QK_W'(plo_q);

  always_ff @(posedge clk_i) begin
    // stage 1: offset from source, phase
    for (int i = 0; i < 3; i++)
      r1_q[i] <= sat_coord(WIDE_W'(face_c[i]) - WIDE_W'(sp_c[i]));
    ph_q <= ft[PHASE_W-1:0];
    // stage 2: axial products, sine lookup
    for (int i = 0; i < 3; i++) begin
      ra_q[i] <= PROD_W'(r1_q[i]) * PROD_W'(ax_c[i]);
      r2_q[i] <= r1_q[i];
    end
    sin_q <= SIN_TAB[ph_q[PHASE_W-1 -: TAB_AW]];
    // stage 3: axial distance, amplitude times sine
    d_q  <= sat_coord(dsum);
    as_q <= 38'(signed'(amp_q)) * 38'(sin_q);
    for (int i = 0; i < 3; i++) r3_q[i] <= r2_q[i];
    // stage 4: projection onto the axis
    for (int i = 0; i < 3; i++) begin
      da_q[i] <= PROD_W'(d_q) * PROD_W'(ax_c[i]);
      r4_q[i] <= r3_q[i];
    end
    s1_q[0] <= 22'(as_q >>> 16);
    for (int j = 1; j < S1_DLY; j++) s1_q[j] <= s1_q[j-1];
    // stage 5: radial offset
    for (int i = 0; i < 3; i++)
      b_q[i] <= sat_coord(WIDE_W'(r4_q[i]) - WIDE_W'(da_q[i] >>> FRAC));
    // stage 6: squares
    for (int i = 0; i < 3; i++) bb_q[i] <= PROD_W'(b_q[i]) * PROD_W'(b_q[i]);
    // stage 7: squared radial distance
    q_q <= Q_W'(bb_q[0][PROD_W-1:FRAC]) + Q_W'(bb_q[1][PROD_W-1:FRAC])
         + Q_W'(bb_q[2][PROD_W-1:FRAC]);
    // stage 8: q times k as two partial products
    plo_q <= 58'(q_q) * 58'(k_q[K_HALF-1:0]);
    phi_q <= 58'(q_q) * 58'(k_q[K_W-1:K_HALF]);
    // stage 9: exp lookup; the term is zero once the argument reaches 16
    if (qk[QK_W-1:EXP_LIM] == '0) e_q <= EXP_TAB[qk[EXP_LIM-1 -: TAB_AW]];
    else                          e_q <= '0;
    // stage 10: gust scale
    se_q <= 40'(s1_q[S1_DLY-1]) * 40'(signed'({1'b0, e_q}));
    // stage 11: along the gust direction
    for (int i = 0; i < 3; i++)
      g_q[i] <= 44'(se_q >>> 16) * 44'(dir_c[i]);
    // stage 12: add reference and saturate, or pass the reference alone when disabled
    for (int i = 0; i < 3; i++)
      vel_q[i] <= enable_q ? sat_coord(WIDE_W'(ref_c[i]) + WIDE_W'(g_q[i] >>> FRAC))
                           : ref_c[i];
  end

  assign vel_x_o = vel_q[0];
  assign vel_y_o = vel_q[1];
  assign vel_z_o = vel_q[2];

endmodule
`default_nettype wire

### sim/gaussian_gust_inlet_velocity_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_gust_inlet_velocity_test
// Self-checking bench for the Gaussian gust inlet block. A directed list of
// register writes and face words runs first, then phases of random settings
// and random faces, mostly placed near the gust source. Every velocity word is
// compared to a given word or an in-bench model of fixed-point arithmetic.
// ----------------------------------------------------------------------------
module gaussian_gust_inlet_velocity_test;
  import ggiv_pkg::*;

  localparam int  LUT_N    = 256;
  localparam int  PIPE_LAT = 12;
  localparam int  STALL_LIMIT = 2000;
  localparam longint PI_30  = 64'sd3373259426;
  localparam longint ONE_30 = 64'sd1073741824;
  localparam logic signed [19:0] C_MAX = 20'sh7FFFF;
  localparam logic signed [19:0] C_MIN = 20'sh80000;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
  } vel_t;

  typedef struct {
    bit                 is_write;
    reg_idx_e           idx;
    logic [63:0]        val;
    logic signed [19:0] fx, fy, fz;
    logic [31:0]        tm;
    bit                 typed;
    vel_t               known;
  } plan_step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [19:0] face_x_i = '0, face_y_i = '0, face_z_i = '0;
  logic [31:0] sim_time_i = '0;
  logic valid_o;
  logic signed [19:0] vel_x_o, vel_y_o, vel_z_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  gaussian_gust_inlet_velocity dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .face_x_i(face_x_i), .face_y_i(face_y_i), .face_z_i(face_z_i),
    .sim_time_i(sim_time_i), .valid_o(valid_o),
    .vel_x_o(vel_x_o), .vel_y_o(vel_y_o), .vel_z_o(vel_z_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Shadow copy of the register file and the derived Gaussian factor.
  logic [59:0]        sh_ref, sh_dir, sh_src, sh_axis;
  logic signed [19:0] sh_amp;
  logic [19:0]        sh_freq, sh_width;
  bit                 sh_enable;
  longint             gauss_k;

  longint sin_lut [LUT_N];
  longint exp_lut [LUT_N];

  vel_t       pending_vel[$];
  plan_step_t plan[$];
  int         error_count = 0;
  int         faces_sent = 0;
  int         velocities_checked = 0;
  int         idle_pct = 0;
  int         quiet_cycles = 0;

  // Sine and exp tables from the same integer series the block uses.
  initial begin : build_luts
    longint th, t2, term, acc, y;
    bit     neg;
    for (int i = 0; i < LUT_N; i++) begin
      th  = (2 * PI_30 * i) / LUT_N;
      neg = 1'b0;
      if (th > PI_30) begin
        th  = th - PI_30;
        neg = 1'b1;
      end
      if (th > PI_30 / 2) th = PI_30 - th;
      t2   = (th * th) >>> 30;
      term = th;
      acc  = th;
      for (int n = 1; n <= 6; n++) begin
        term = -(((term * t2) >>> 30) / longint'((2 * n) * (2 * n + 1)));
        acc  = acc + term;
      end
      if (neg) acc = -acc;
      sin_lut[i] = (acc + 64'sd8192) >>> 14;

      y    = (((64'sd16 <<< 30) * i) / LUT_N) >>> 4;
      term = ONE_30;
      acc  = ONE_30;
      for (int n = 1; n <= 12; n++) begin
        term = -(((term * y) >>> 30) / longint'(n));
        acc  = acc + term;
      end
      if (acc < 0) acc = 0;
      for (int n = 0; n < 4; n++) acc = (acc * acc) >>> 30;
      exp_lut[i] = (acc + 64'sd8192) >>> 14;
    end
  end

  function automatic longint clamp_coord(input longint v);
    if (v > 64'sd524287) return 64'sd524287;
    if (v < -64'sd524288) return -64'sd524288;
    return v;
  endfunction

  function automatic longint lane(input logic [59:0] pack, input int i);
    logic signed [19:0] c;
    c = pack[i*20 +: 20];
    return longint'(c);
  endfunction

  task automatic shadow_write(input reg_idx_e idx, input logic [63:0] v);
    longint r;
    case (idx)
      REG_REF_VEL:   sh_ref = v[59:0];
      REG_GUST_DIR:  sh_dir = v[59:0];
      REG_SRC_POINT: sh_src = v[59:0];
      REG_SRC_AXIS:  sh_axis = v[59:0];
      REG_AMPLITUDE: sh_amp = v[19:0];
      REG_FREQUENCY: sh_freq = v[19:0];
      REG_WIDTH: begin
        sh_width = v[19:0];
        r = longint'(sh_width);
        if (r == 0) r = 1;
        gauss_k = (64'sd1 <<< 51) / (r * r);
      end
      REG_ENABLE:    sh_enable = v[0];
      default: ;
    endcase
  endtask

  function automatic vel_t predict_velocity(input logic signed [19:0] fx, fy, fz,
                                            input logic [31:0] tm);
    longint f[3], rel[3], ax[3], bv[3];
    longint d, q, lim, x, e, s, v, ph;
    logic [19:0] o[3];
    d = 0; q = 0; e = 0; s = 0;
    f[0] = fx; f[1] = fy; f[2] = fz;
    if (sh_enable) begin
      for (int i = 0; i < 3; i++) begin
        rel[i] = clamp_coord(f[i] - lane(sh_src, i));
        ax[i]  = lane(sh_axis, i);
        d      = d + ((rel[i] * ax[i]) >>> 10);
      end
      d = clamp_coord(d);
      for (int i = 0; i < 3; i++) begin
        bv[i] = clamp_coord(rel[i] - ((d * ax[i]) >>> 10));
        q     = q + ((bv[i] * bv[i]) >>> 10);
      end
      // Past the table range the Gaussian weight is taken as zero.
      lim = (64'sd16 <<< 42) / gauss_k;
      if (q <= lim) begin
        x = (q * gauss_k) >>> 26;
        if (x < (64'sd16 <<< 16)) e = exp_lut[(x * LUT_N) / (64'sd16 <<< 16)];
      end
      ph = (longint'(sh_freq) * longint'(tm)) & ((64'sd1 <<< 26) - 1);
      s  = (longint'(sh_amp) * sin_lut[(ph * LUT_N) >>> 26]) >>> 16;
      s  = (s * e) >>> 16;
    end
    for (int i = 0; i < 3; i++) begin
      v = lane(sh_ref, i);
      if (sh_enable) v = clamp_coord(v + ((s * lane(sh_dir, i)) >>> 10));
      o[i] = v[19:0];
    end
    return '{x: o[0], y: o[1], z: o[2]};
  endfunction

  task automatic report_mismatch(input string field, input logic signed [19:0] got,
                                 input logic signed [19:0] want);
    error_count++;
    $display("[%0t] %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // Velocity words are checked in the middle of their one-cycle window.
  always @(negedge clk_i) begin
    vel_t want;
    if (rst_ni && valid_o) begin
      if (pending_vel.size() == 0) begin
        error_count++;
        $display("[%0t] velocity word with no face outstanding", $realtime);
      end else begin
        want = pending_vel.pop_front();
        velocities_checked++;
        if (vel_x_o !== want.x) report_mismatch("vel_x", vel_x_o, want.x);
        if (vel_y_o !== want.y) report_mismatch("vel_y", vel_y_o, want.y);
        if (vel_z_o !== want.z) report_mismatch("vel_z", vel_z_o, want.z);
      end
    end
  end

  always @(negedge clk_i) begin
    if ((start && !busy) || valid_o || psel || !rst_ni) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Registers change only with the pipe empty, which this task waits for.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    wait (pending_vel.size() == 0);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    shadow_write(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_face(input logic signed [19:0] fx, fy, fz, input logic [31:0] tm,
                           input bit typed, input vel_t known);
    bit was_busy;
    start      <= 1'b1;
    face_x_i   <= fx;
    face_y_i   <= fy;
    face_z_i   <= fz;
    sim_time_i <= tm;
    do begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
    end while (was_busy);
    pending_vel.push_back(typed ? known : predict_velocity(fx, fy, fz, tm));
    faces_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic plan_write(input reg_idx_e idx, input logic [63:0] v);
    plan_step_t p;
    p = '{idx: REG_REF_VEL, default: '0};
    p.is_write = 1'b1;
    p.idx = idx;
    p.val = v;
    plan.push_back(p);
  endtask

  task automatic plan_face(input logic signed [19:0] fx, fy, fz, input logic [31:0] tm,
                           input bit typed, input vel_t known);
    plan_step_t p;
    p = '{idx: REG_REF_VEL, default: '0};
    p.fx = fx; p.fy = fy; p.fz = fz; p.tm = tm;
    p.typed = typed;
    p.known = known;
    plan.push_back(p);
  endtask

  function automatic logic [59:0] pack3(input logic signed [19:0] x, y, z);
    return {z, y, x};
  endfunction

  function automatic logic [59:0] rand60();
    return {$urandom, $urandom};
  endfunction

  // Level 1 pushes most registers high, level 2 most low, level 0 is random.
  task automatic randomize_setup(input int level);
    logic [59:0] axis;
    int          k;
    if (level == 1) begin
      apb_write(REG_REF_VEL, pack3(C_MAX, C_MAX, C_MAX));
      apb_write(REG_GUST_DIR, pack3(C_MAX, C_MAX, C_MAX));
      apb_write(REG_AMPLITUDE, 64'h7FFFF);
      apb_write(REG_FREQUENCY, 64'hFFFFF);
      apb_write(REG_WIDTH, 64'hFFFFF);
    end else if (level == 2) begin
      apb_write(REG_REF_VEL, pack3(C_MIN, C_MIN, C_MIN));
      apb_write(REG_GUST_DIR, pack3(C_MIN, 20'sd1024, C_MIN));
      apb_write(REG_AMPLITUDE, 64'h80000);
      apb_write(REG_FREQUENCY, 64'd1);
      apb_write(REG_WIDTH, 64'd1);
    end else begin
      apb_write(REG_REF_VEL, rand60());
      apb_write(REG_GUST_DIR, $urandom_range(1) ? rand60()
                : pack3($signed(20'($urandom_range(2048))) - 20'sd1024,
                        $signed(20'($urandom_range(2048))) - 20'sd1024,
                        $signed(20'($urandom_range(2048))) - 20'sd1024));
      apb_write(REG_AMPLITUDE, 64'($urandom_range(20'hFFFFF)));
      apb_write(REG_FREQUENCY, 64'($urandom_range(20'hFFFFF)));
      apb_write(REG_WIDTH, $urandom_range(3) == 0 ? 64'($urandom_range(1, 20'hFFFFF))
                                                  : 64'($urandom_range(1, 8192)));
    end
    k    = $urandom_range(2);
    axis = '0;
    axis[k*20 +: 20] = ($urandom_range(1) ? 20'sd1024 : -20'sd1024);
    apb_write(REG_SRC_AXIS, $urandom_range(4) == 0 ? rand60() : axis);
    apb_write(REG_SRC_POINT, level == 0 ? rand60()
              : pack3($signed(20'($urandom)), $signed(20'($urandom)), 20'sd0));
    apb_write(REG_ENABLE, (level != 0 || $urandom_range(6) != 0) ? 64'd1 : 64'd0);
  endtask

  function automatic logic signed [19:0] near_lane(input int i);
    longint w, off;
    w   = longint'(sh_width) * 3 + 1;
    if (w > 64'sd524287) w = 64'sd524287;
    off = longint'($urandom_range(0, 2 * w)) - w;
    return clamp_coord(lane(sh_src, i) + off);
  endfunction

  initial begin : stimulus
    vel_t ref_only, none;
    plan_step_t p;
    none = '0;
    ref_only = '{x: 20'sd1024, y: 20'sd0, z: 20'sd0};

    // Defaults: zero amplitude leaves the reference velocity alone.
    plan_face(20'sd0, 20'sd0, 20'sd0, 32'd0, 1'b1, ref_only);
    plan_face(C_MAX, C_MAX, C_MAX, 32'hFFFF_FFFF, 1'b1, ref_only);
    plan_face(C_MIN, C_MIN, C_MIN, 32'd0, 1'b1, ref_only);
    plan_face(C_MAX, C_MIN, 20'sd1, 32'h8000_0000, 1'b1, ref_only);
    // Half amplitude at 1 Hz: quarter turn, half turn, three quarters.
    plan_write(REG_AMPLITUDE, 64'd512);
    plan_write(REG_FREQUENCY, 64'd1024);
    plan_face(20'sd0, 20'sd3000, 20'sd0, 32'd16384, 1'b0, none);
    plan_face(20'sd0, 20'sd0, 20'sd0, 32'd32768, 1'b0, none);
    plan_face(20'sd512, 20'sd0, 20'sd0, 32'd49152, 1'b0, none);
    // Far from the axis the Gaussian weight drops, to zero for the farthest face.
    plan_face(C_MAX, 20'sd0, C_MIN, 32'd16384, 1'b0, none);
    plan_face(20'sd4000, 20'sd0, 20'sd0, 32'd16384, 1'b0, none);
    // Saturation of every lane with maximal amplitude and direction.
    plan_write(REG_REF_VEL, pack3(C_MAX, C_MIN, C_MAX));
    plan_write(REG_GUST_DIR, pack3(C_MAX, C_MAX, C_MIN));
    plan_write(REG_AMPLITUDE, 64'h7FFFF);
    plan_face(20'sd0, 20'sd0, 20'sd0, 32'd16384, 1'b0, none);
    plan_face(20'sd0, 20'sd0, 20'sd0, 32'd49152, 1'b0, none);
    // A zero radius acts as the smallest one.
    plan_write(REG_WIDTH, 64'd0);
    plan_face(20'sd0, 20'sd77, 20'sd0, 32'd16384, 1'b0, none);
    plan_face(20'sd1, 20'sd0, 20'sd0, 32'd16384, 1'b0, none);
    plan_write(REG_WIDTH, 64'hFFFFF);
    plan_write(REG_SRC_POINT, pack3(C_MAX, C_MIN, 20'sd5));
    plan_write(REG_SRC_AXIS, pack3(20'sd724, 20'sd0, 20'sd724));
    plan_face(C_MIN, C_MAX, 20'sd0, 32'h1234_5678, 1'b0, none);
    plan_face(C_MAX, C_MIN, 20'sd5, 32'hFFFF_FFFF, 1'b0, none);
    // Steady case: only the reference comes out.
    plan_write(REG_ENABLE, 64'd0);
    plan_face(20'sd0, 20'sd0, 20'sd0, 32'd16384, 1'b1,
              '{x: C_MAX, y: C_MIN, z: C_MAX});
    plan_face(C_MIN, C_MAX, C_MIN, 32'hFFFF_FFFF, 1'b1,
              '{x: C_MAX, y: C_MIN, z: C_MAX});

    shadow_write(REG_REF_VEL, 64'd1024);
    shadow_write(REG_GUST_DIR, 64'd1024 << 40);
    shadow_write(REG_SRC_POINT, 64'd0);
    shadow_write(REG_SRC_AXIS, 64'd1024 << 20);
    shadow_write(REG_AMPLITUDE, 64'd0);
    shadow_write(REG_FREQUENCY, 64'd0);
    shadow_write(REG_WIDTH, 64'd1024);
    shadow_write(REG_ENABLE, 64'd1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    foreach (plan[i]) begin
      p = plan[i];
      if (p.is_write) begin
        wait_drained();
        apb_write(p.idx, p.val);
      end else begin
        send_face(p.fx, p.fy, p.fz, p.tm, p.typed, p.known);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      idle_pct = (mode == 0) ? 7 : (mode == 1) ? 47 : 0;
      for (int ph = 0; ph < 5; ph++) begin
        wait_drained();
        randomize_setup(ph == 0 ? (mode == 2 ? 0 : mode + 1) : 0);
        for (int n = 0; n < 50; n++) begin
          if ($urandom_range(9) < 7)
            send_face(near_lane(0), near_lane(1), near_lane(2),
                      $urandom_range(3) == 0 ? $urandom : $urandom_range(20'hFFFFF),
                      1'b0, none);
          else
            send_face($signed(20'($urandom)), $signed(20'($urandom)),
                      $signed(20'($urandom)), $urandom, 1'b0, none);
        end
      end
    end

    start <= 1'b0;
    wait (pending_vel.size() == 0);
    repeat (PIPE_LAT + 8) @(posedge clk_i);
    $display("Sent %0d faces over three idle patterns and 15 register settings;",
             faces_sent);
    $display("checked %0d velocity words, %0d mismatches.", velocities_checked, error_count);
    if (error_count == 0 && pending_vel.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ggiv_pkg.sv
rtl/gaussian_gust_inlet_velocity.sv
sim/gaussian_gust_inlet_velocity_test.sv
